// File: rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants for the lottery slot arbiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsa_pkg;

    // fixed field widths
    localparam int unsigned SLOT_W = 6;
    localparam int unsigned TCNT_W = 16;
    localparam int unsigned MASK_W = 64;
    localparam int unsigned DRAW_W = 10;
    localparam int unsigned LCG_W  = 32;
    localparam int unsigned STEP_W = 6;

    // generator and draw constants
    localparam logic [LCG_W-1:0]  LCG_MUL       = 32'd38;
    localparam logic [LCG_W-1:0]  LCG_ADD       = 32'd2;
    localparam logic [DRAW_W-1:0] DRAW_MOD      = 10'd1007;
    localparam int unsigned       RESET_TICKETS = 10;

    // 2^DRAW_W minus the draw modulus, weight of the bits above DRAW_W
    localparam logic [LCG_W-1:0]  DRAW_FOLD     = 32'd17;

    // transaction modes
    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic [TCNT_W-1:0] ticket_count;
        logic [MASK_W-1:0] runnable_mask;
    } in_t;

    typedef struct packed {
        logic              grant_valid;
        logic [SLOT_W-1:0] grant_slot;
        logic [DRAW_W-1:0] draw_value;
    } out_t;

    // ticket memory ports
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } mem_req_t;

    // remainder unit command
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [LCG_W-1:0]  dividend;
    } rem_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MOD_DRAW,
        ST_MOD_TOTAL,
        ST_PICK,
        ST_DONE
    } state_t;

endpackage

// File: rtl/lsa_ticket_mem.sv
// ----------------------------------------------------------------------------
// lsa_ticket_mem
// Ticket count memory, one write and one registered read per cycle; entries
// never written read as the reset ticket count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsa_ticket_mem #(
    parameter int unsigned NUM_SLOTS   = 64,
    parameter int unsigned TICKET_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lsa_pkg::mem_req_t      wr,
    input  logic [TICKET_BITS-1:0] wdata,
    input  lsa_pkg::mem_req_t      rd,
    output logic [TICKET_BITS-1:0] rdata
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [TICKET_BITS-1:0] ticket_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   written_reg;
    logic [TICKET_BITS-1:0] q_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       rd_idx;

    assign wr_idx = wr.addr[IDX_W-1:0];
    assign rd_idx = rd.addr[IDX_W-1:0];

    // storage array and registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            ticket_mem[wr_idx] <= wdata;
        end
        if (rd.en) begin
            q_reg <= ticket_mem[rd_idx];
        end
    end

    // per-entry written flags, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            if (wr.en) begin
                written_reg[wr_idx] <= 1'b1;
            end
            if (rd.en) begin
                hit_reg <= written_reg[rd_idx];
            end
        end
    end

    assign rdata = hit_reg ? q_reg : TICKET_BITS'(lsa_pkg::RESET_TICKETS);

endmodule

// File: rtl/lsa_rem_unit.sv
// ----------------------------------------------------------------------------
// lsa_rem_unit
// Restoring remainder unit, one dividend bit per cycle, for the modulo of
// the drawn value by the ticket total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsa_rem_unit #(
    parameter int unsigned DIV_W = 22
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lsa_pkg::rem_cmd_t   cmd,
    input  logic [DIV_W-1:0]    divisor,
    output logic                busy,
    output logic [DIV_W-1:0]    rem
);

    logic                              busy_reg,  busy_next;
    logic [lsa_pkg::STEP_W-1:0]        cnt_reg,   cnt_next;
    logic [lsa_pkg::LCG_W-1:0]         dvd_reg,   dvd_next;
    logic [DIV_W-1:0]                  div_reg,   div_next;
    logic [DIV_W-1:0]                  rem_reg,   rem_next;
    logic [DIV_W:0]                    trial;
    logic [DIV_W:0]                    diff;

    // one shift-compare-subtract step
    always_comb begin
        trial     = {rem_reg, dvd_reg[lsa_pkg::LCG_W-1]};
        diff      = trial - {1'b0, div_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            dvd_next  = cmd.dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[lsa_pkg::LCG_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, div_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lsa_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/lottery_slot_arbiter_core.sv
// ----------------------------------------------------------------------------
// lottery_slot_arbiter_core
// Lottery arbiter over a set of slots with per-slot ticket counts.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_payload): a set transaction (mode 0)
// writes one slot's ticket count and gives no result; a draw transaction
// (mode 1) carries the runnable mask and gives exactly one result.
// Result channel (m_valid/m_ready/m_payload): grant_valid, grant_slot and the
// drawn ticket number; a zero ticket total gives a result with no grant.
// A draw walks the ticket memory twice through its single read port (the
// second walk stops at the winner) and runs a serial modulo by the total
// between the two walks. The modulo by 1007 folds the generator value
// alongside the first walk. One transaction is worked on at a time;
// s_ready is high whenever the arbiter is idle.
// The result sits in an output register, so the next transaction is taken
// while a result waits for m_ready; a further draw waits at its end until
// the register frees up.
// Reset sets every ticket count to 10 and the generator to zero at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lottery_slot_arbiter_core #(
    parameter int unsigned NUM_SLOTS   = 64,
    parameter int unsigned TICKET_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lsa_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output lsa_pkg::out_t m_payload
);

    localparam int unsigned IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int unsigned TOTAL_W = TICKET_BITS + IDX_W;
    localparam int unsigned DIV_W   = (TOTAL_W > lsa_pkg::DRAW_W) ? TOTAL_W : lsa_pkg::DRAW_W;
    localparam int unsigned EXT_W   = (TICKET_BITS > lsa_pkg::TCNT_W) ? TICKET_BITS
                                                                        : lsa_pkg::TCNT_W;

    lsa_pkg::state_t          state_reg,  state_next;
    logic [CNT_W-1:0]         cnt_reg,    cnt_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [NUM_SLOTS-1:0]     mask_reg,   mask_next;
    logic [TOTAL_W-1:0]       total_reg,  total_next;
    logic [TOTAL_W-1:0]       run_reg,    run_next;
    logic [lsa_pkg::DRAW_W-1:0] draw_reg, draw_next;
    logic [lsa_pkg::LCG_W-1:0]  lcg_reg,  lcg_next;
    logic [lsa_pkg::LCG_W-1:0]  red_reg,  red_next;
    lsa_pkg::out_t            res_reg,    res_next;
    logic                     m_valid_reg, m_valid_next;
    lsa_pkg::out_t            m_payload_reg, m_payload_next;

    lsa_pkg::mem_req_t        mem_wr;
    lsa_pkg::mem_req_t        mem_rd;
    logic [EXT_W-1:0]         tcnt_ext;
    logic [TICKET_BITS-1:0]   mem_wdata;
    logic [TICKET_BITS-1:0]   mem_rdata;
    lsa_pkg::rem_cmd_t        rem_cmd;
    logic [DIV_W-1:0]         rem_divisor;
    logic                     rem_busy;
    logic [DIV_W-1:0]         rem_res;

    logic                     s_accept;
    logic                     issue;
    logic                     take;
    logic [TOTAL_W-1:0]       run_sum;

    assign s_accept  = s_valid && s_ready;
    assign tcnt_ext  = EXT_W'(s_payload.ticket_count);
    assign mem_wdata = tcnt_ext[TICKET_BITS-1:0];

    // ticket write from a set transaction, slots past the end are dropped
    always_comb begin
        mem_wr.en   = s_accept && (s_payload.mode == lsa_pkg::MODE_SET)
                      && (s_payload.slot < lsa_pkg::SLOT_W'(NUM_SLOTS - 1) + 1'b1
                          || NUM_SLOTS > (1 << lsa_pkg::SLOT_W) - 1);
        mem_wr.addr = s_payload.slot;
    end

    lsa_ticket_mem #(
        .NUM_SLOTS   (NUM_SLOTS),
        .TICKET_BITS (TICKET_BITS)
    ) u_ticket_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (mem_wr),
        .wdata   (mem_wdata),
        .rd      (mem_rd),
        .rdata   (mem_rdata)
    );

    lsa_rem_unit #(
        .DIV_W (DIV_W)
    ) u_rem_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (rem_cmd),
        .divisor (rem_divisor),
        .busy    (rem_busy),
        .rem     (rem_res)
    );

    // memory walk: one read issued per cycle, data in the next cycle
    assign take    = rd_vld_reg && mask_reg[rd_idx_reg];
    assign run_sum = run_reg + (take ? TOTAL_W'(mem_rdata) : '0);

    // generator value reduced mod 1007, one fold of the high bits per cycle, then a subtraction of 1007
    always_comb begin
        red_next = red_reg;
        if (s_accept && s_payload.mode == lsa_pkg::MODE_DRAW) begin
            red_next = lcg_next;
        end else if (red_reg[lsa_pkg::LCG_W-1:lsa_pkg::DRAW_W] != '0) begin
            red_next = (red_reg >> lsa_pkg::DRAW_W) * lsa_pkg::DRAW_FOLD
                       + lsa_pkg::LCG_W'(red_reg[lsa_pkg::DRAW_W-1:0]);
        end else if (red_reg >= lsa_pkg::LCG_W'(lsa_pkg::DRAW_MOD)) begin
            red_next = red_reg - lsa_pkg::LCG_W'(lsa_pkg::DRAW_MOD);
        end
    end

    // sequencer: next state and datapath controls
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mask_next      = mask_reg;
        total_next     = total_reg;
        run_next       = run_reg;
        draw_next      = draw_reg;
        lcg_next       = lcg_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        s_ready        = 1'b0;
        issue          = 1'b0;
        rem_cmd        = '0;
        rem_divisor    = DIV_W'(total_reg);

        case (state_reg)
            lsa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_accept && s_payload.mode == lsa_pkg::MODE_DRAW) begin
                    lcg_next         = lsa_pkg::LCG_W'(lcg_reg * lsa_pkg::LCG_MUL)
                                       + lsa_pkg::LCG_ADD;
                    mask_next        = s_payload.runnable_mask[NUM_SLOTS-1:0];
                    cnt_next         = '0;
                    total_next       = '0;
                    state_next       = lsa_pkg::ST_SUM;
                end
            end

            lsa_pkg::ST_SUM: begin
                issue = (cnt_reg < CNT_W'(NUM_SLOTS));
                if (issue) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (take) begin
                    total_next = total_reg + TOTAL_W'(mem_rdata);
                end
                if (rd_vld_reg && rd_idx_reg == IDX_W'(NUM_SLOTS - 1)) begin
                    state_next = lsa_pkg::ST_MOD_DRAW;
                end
            end

            lsa_pkg::ST_MOD_DRAW: begin
                if (!rem_busy && red_reg < lsa_pkg::LCG_W'(lsa_pkg::DRAW_MOD)) begin
                    if (total_reg == '0) begin
                        res_next   = '0;
                        state_next = lsa_pkg::ST_DONE;
                    end else begin
                        rem_cmd.start    = 1'b1;
                        rem_cmd.steps    = lsa_pkg::STEP_W'(lsa_pkg::DRAW_W);
                        rem_cmd.dividend = {red_reg[lsa_pkg::DRAW_W-1:0],
                                            {(lsa_pkg::LCG_W - lsa_pkg::DRAW_W){1'b0}}};
                        rem_divisor      = DIV_W'(total_reg);
                        state_next       = lsa_pkg::ST_MOD_TOTAL;
                    end
                end
            end

            lsa_pkg::ST_MOD_TOTAL: begin
                if (!rem_busy) begin
                    draw_next  = rem_res[lsa_pkg::DRAW_W-1:0] + 1'b1;
                    cnt_next   = '0;
                    run_next   = '0;
                    state_next = lsa_pkg::ST_PICK;
                end
            end

            lsa_pkg::ST_PICK: begin
                if (take && DIV_W'(run_sum) >= DIV_W'(draw_reg)) begin
                    res_next.grant_valid = 1'b1;
                    res_next.grant_slot  = lsa_pkg::SLOT_W'(rd_idx_reg);
                    res_next.draw_value  = draw_reg;
                    state_next           = lsa_pkg::ST_DONE;
                end else begin
                    issue    = (cnt_reg < CNT_W'(NUM_SLOTS));
                    run_next = run_sum;
                    if (issue) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            lsa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = res_reg;
                    state_next     = lsa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lsa_pkg::ST_IDLE;
            end
        endcase

        rd_vld_next = issue;
        rd_idx_next = cnt_reg[IDX_W-1:0];
        mem_rd.en   = issue;
        mem_rd.addr = lsa_pkg::SLOT_W'(cnt_reg[IDX_W-1:0]);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsa_pkg::ST_IDLE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            lcg_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
            lcg_reg     <= lcg_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        rd_idx_reg    <= rd_idx_next;
        mask_reg      <= mask_next;
        total_reg     <= total_next;
        run_reg       <= run_next;
        draw_reg      <= draw_next;
        red_reg       <= red_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: rtl/lsa_checker.sv
// ----------------------------------------------------------------------------
// lsa_checker
// Port-level checks for the lottery slot arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsa_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input lsa_pkg::in_t  s_payload,
    input logic          m_valid,
    input logic          m_ready,
    input lsa_pkg::out_t m_payload
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    // a grant always carries a nonzero draw
    a_grant_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.grant_valid |-> m_payload.draw_value != '0)
        else $error("grant with zero draw value");

    // no grant reads as all zero
    a_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.grant_valid
            |-> m_payload.grant_slot == '0 && m_payload.draw_value == '0)
        else $error("no-grant result with nonzero fields");

    // a set transaction never raises a result
    a_set_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.mode == lsa_pkg::MODE_SET && !m_valid
            |=> !m_valid)
        else $error("result after a set transaction");

endmodule

bind lottery_slot_arbiter_core lsa_checker u_lsa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
